// ----- sv/sfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SLIP frame decoder package
// Marker codes, state encoding and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 6;

  // Marker bytes on the line
  localparam logic [BYTE_W-1:0] MARK_START = 8'hC0;
  localparam logic [BYTE_W-1:0] MARK_END   = 8'hD0;
  localparam logic [BYTE_W-1:0] MARK_ESC   = 8'hDB;

  // Codes that follow an escape byte
  localparam logic [BYTE_W-1:0] CODE_START = 8'hDC;
  localparam logic [BYTE_W-1:0] CODE_ESC   = 8'hDD;
  localparam logic [BYTE_W-1:0] CODE_END   = 8'hDE;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_ESC,
    ST_READ,
    ST_LOAD,
    ST_EMPTY
  } sfd_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;       // store the current byte at the fill position
    logic wr_esc;      // store the unescaped code instead of the raw byte
    logic fill_clr;    // restart the frame
    logic rd_en;       // read the store at the drain index
    logic rd_inc;      // advance the drain index
    logic rd_clr;      // rewind the drain index
    logic load_byte;   // load the output register with a drained byte
    logic load_empty;  // load the output register with the empty marker
  } sfd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic is_esc;
    logic code_ok;     // byte is a valid escape code
    logic full;        // store holds MAX_FRAME bytes
    logic fill_zero;
    logic rd_last;     // drain index points at the final stored byte
    logic out_free;    // output register can take a new result this cycle
  } sfd_status_t;

endpackage

// ----- sv/sfd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SLIP frame decoder controller
// Tracks framing phase and sequences the drain of a completed frame.
// ----------------------------------------------------------------------------
module sfd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sfd_pkg::sfd_status_t stat,
  output sfd_pkg::sfd_cmd_t    cmd
);
  import sfd_pkg::*;

  sfd_state_t state_r;
  sfd_state_t state_nxt;
  logic       acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE) || (state_r == ST_FRAME) || (state_r == ST_ESC);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && stat.is_start) begin
          cmd.fill_clr = 1'b1;
          state_nxt    = ST_FRAME;
        end
      end
      ST_FRAME: begin
        if (acc) begin
          priority if (stat.full) begin
            // drop the frame and discard this byte
            cmd.fill_clr = 1'b1;
            state_nxt    = ST_IDLE;
          end else if (stat.is_start) begin
            cmd.fill_clr = 1'b1;
          end else if (stat.is_end) begin
            state_nxt = stat.fill_zero ? ST_EMPTY : ST_READ;
          end else if (stat.is_esc) begin
            state_nxt = ST_ESC;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_ESC: begin
        if (acc) begin
          priority if (stat.full) begin
            cmd.fill_clr = 1'b1;
            state_nxt    = ST_IDLE;
          end else if (stat.is_start) begin
            cmd.fill_clr = 1'b1;
            state_nxt    = ST_FRAME;
          end else if (stat.code_ok) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_esc = 1'b1;
            state_nxt  = ST_FRAME;
          end else begin
            cmd.fill_clr = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // hold the read data until the output register frees up
        if (stat.out_free) begin
          cmd.load_byte = 1'b1;
          if (stat.rd_last) begin
            cmd.fill_clr = 1'b1;
            cmd.rd_clr   = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.rd_inc = 1'b1;
            state_nxt  = ST_READ;
          end
        end
      end
      ST_EMPTY: begin
        if (stat.out_free) begin
          cmd.load_empty = 1'b1;
          cmd.fill_clr   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/sfd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SLIP frame decoder datapath
// Byte classification, frame store, fill and drain counters, output register.
// ----------------------------------------------------------------------------
module sfd_datapath #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sfd_pkg::BYTE_W-1:0]  in_rx_byte,
  input  sfd_pkg::sfd_cmd_t           cmd,
  output sfd_pkg::sfd_status_t        stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sfd_pkg::BYTE_W-1:0]  out_frame_byte,
  output logic [sfd_pkg::POS_W-1:0]   out_byte_position,
  output logic [sfd_pkg::POS_W-1:0]   out_frame_length,
  output logic                        out_empty_frame,
  output logic                        out_last
);
  import sfd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FRAME);
  localparam int unsigned FW = $clog2(MAX_FRAME + 1);

  logic [BYTE_W-1:0] store_mem [MAX_FRAME];

  logic [FW-1:0]     fill_r;
  logic [FW-1:0]     fill_nxt;
  logic [FW-1:0]     rd_idx_r;
  logic [FW-1:0]     rd_idx_nxt;
  logic [BYTE_W-1:0] rd_data_r;
  logic [BYTE_W-1:0] esc_val;
  logic              esc_ok;
  logic [BYTE_W-1:0] wr_data;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [POS_W-1:0]  out_len_r;
  logic              out_empty_r;
  logic              out_last_r;

  // Escape code to marker byte
  always_comb begin
    esc_val = '0;
    esc_ok  = 1'b0;
    unique case (in_rx_byte)
      CODE_START: begin
        esc_val = MARK_START;
        esc_ok  = 1'b1;
      end
      CODE_ESC: begin
        esc_val = MARK_ESC;
        esc_ok  = 1'b1;
      end
      CODE_END: begin
        esc_val = MARK_END;
        esc_ok  = 1'b1;
      end
      default: begin
        esc_val = '0;
        esc_ok  = 1'b0;
      end
    endcase
  end

  assign wr_data = cmd.wr_esc ? esc_val : in_rx_byte;

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store_mem[fill_r[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= store_mem[rd_idx_r[AW-1:0]];
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.fill_clr) begin
      fill_nxt = '0;
    end else if (cmd.wr_en) begin
      fill_nxt = fill_r + FW'(1);
    end
  end

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.rd_clr) begin
      rd_idx_nxt = '0;
    end else if (cmd.rd_inc) begin
      rd_idx_nxt = rd_idx_r + FW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_byte || cmd.load_empty) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      out_byte_r  <= rd_data_r;
      out_pos_r   <= POS_W'(rd_idx_r);
      out_len_r   <= POS_W'(fill_r);
      out_empty_r <= 1'b0;
      out_last_r  <= stat.rd_last;
    end else if (cmd.load_empty) begin
      out_byte_r  <= '0;
      out_pos_r   <= '0;
      out_len_r   <= '0;
      out_empty_r <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign stat.is_start  = (in_rx_byte == MARK_START);
  assign stat.is_end    = (in_rx_byte == MARK_END);
  assign stat.is_esc    = (in_rx_byte == MARK_ESC);
  assign stat.code_ok   = esc_ok;
  assign stat.full      = (fill_r == FW'(MAX_FRAME));
  assign stat.fill_zero = (fill_r == '0);
  assign stat.rd_last   = ((rd_idx_r + FW'(1)) == fill_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_frame_byte    = out_byte_r;
  assign out_byte_position = out_pos_r;
  assign out_frame_length  = out_len_r;
  assign out_empty_frame   = out_empty_r;
  assign out_last          = out_last_r;

endmodule

// ----- sv/slip_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SLIP frame decoder
// Strips start/end/escape framing from a received byte stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_rx_byte) takes one line byte per
// request. While collecting a frame the block accepts a byte every cycle.
// Decoded bytes go into a MAX_FRAME-entry store; a start byte restarts the
// frame, a bad escape code or a byte arriving with the store full drops it.
// On an end byte the input closes and the store is drained: each result
// takes a store read and then an output register load, and the input
// stays closed until the last byte of the frame has been loaded. A
// zero-length frame yields one result flagged empty_frame. Results leave
// through a single output register (out_valid/out_ready); while the
// receiver stalls the drain holds, and the final result can wait there
// while the next frame's bytes are already accepted.
// Reset (rst_n low, synchronous) returns the block to idle, waiting for a
// start byte, with the store empty and no result pending.
// ----------------------------------------------------------------------------
module slip_frame_decoder #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sfd_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sfd_pkg::BYTE_W-1:0]  out_frame_byte,
  output logic [sfd_pkg::POS_W-1:0]   out_byte_position,
  output logic [sfd_pkg::POS_W-1:0]   out_frame_length,
  output logic                        out_empty_frame,
  output logic                        out_last
);
  import sfd_pkg::*;

  sfd_cmd_t    cmd;
  sfd_status_t stat;

  sfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfd_datapath #(
    .MAX_FRAME (MAX_FRAME)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_byte    (out_frame_byte),
    .out_byte_position (out_byte_position),
    .out_frame_length  (out_frame_length),
    .out_empty_frame   (out_empty_frame),
    .out_last          (out_last)
  );

endmodule
